### rtl/ble_pkg.sv
`timescale 1ns / 1ps

package ble_pkg;

    localparam int SAMPLE_W = 12;
    localparam int ENTRY_W  = 13;
    localparam int LEVEL_W  = 7;
    localparam int OFFS_W   = 8;
    localparam int THR_W    = 7;
    localparam int SHUT_W   = 3;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 8;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;
    localparam logic [SHUT_W-1:0]  ZERO_RUN_MAX = 3'd7;

    // Register indexes of the configuration port
    localparam logic [CFG_AW-1:0] CFG_IDX_CHARGE_OFFSET  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_IDX_LOW_THRESHOLD  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_IDX_SHUTDOWN_AFTER = 2'd2;

    localparam logic [OFFS_W-1:0] CHARGE_OFFSET_RST  = 8'd30;
    localparam logic [THR_W-1:0]  LOW_THRESHOLD_RST  = 7'd15;
    localparam logic [SHUT_W-1:0] SHUTDOWN_AFTER_RST = 3'd5;

    // Battery voltage in mV at 0, 10, ... 100 percent
    localparam int VOLT_POINTS = 11;
    localparam logic [SAMPLE_W-1:0] VOLT_TABLE [VOLT_POINTS] = '{
        12'd3411, 12'd3556, 12'd3635, 12'd3668, 12'd3691, 12'd3719,
        12'd3759, 12'd3811, 12'd3873, 12'd3947, 12'd4031
    };

    typedef struct packed {
        logic push;
        logic rotate;
    } win_ctrl_t;

    function automatic logic [ENTRY_W-1:0] sub_sat(
        input logic [ENTRY_W-1:0] v,
        input logic [OFFS_W-1:0]  d,
        input logic               en
    );
        logic [ENTRY_W-1:0] dd;
        begin
            dd = en ? ENTRY_W'(d) : '0;
            return (v > dd) ? (v - dd) : '0;
        end
    endfunction

endpackage

### rtl/ble_div.sv
`timescale 1ns / 1ps

module ble_div #(
    parameter int DIV_W = 20,
    parameter int DEN_W = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    // one restoring step: bring down the next dividend bit
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/ble_window.sv
`timescale 1ns / 1ps

module ble_window #(
    parameter int DEPTH = 10,
    parameter int W     = 13
) (
    input  logic                aclk,
    input  ble_pkg::win_ctrl_t  ctrl,
    input  logic [W-1:0]        push_data,
    output logic [W-1:0]        head
);

    import ble_pkg::*;

    logic [W-1:0] win_reg [DEPTH];
    logic [W-1:0] tail_in;

    // rotate feeds the oldest entry back in at the tail
    assign tail_in = ctrl.push ? push_data : win_reg[0];

    always_ff @(posedge aclk) begin
        if (ctrl.push || ctrl.rotate) begin
            for (int i = 0; i + 1 < DEPTH; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[DEPTH-1] <= tail_in;
        end
    end

    assign head = win_reg[0];

endmodule

### rtl/battery_level_estimator_top.sv
`timescale 1ns / 1ps
// Flow: a sample inside a burst is taken while in ST_IDLE; a burst-ending sample gives
// its result after the burst average, window push and sum, window average, serial divide.
// Clipping to 0 or 100 skips the divide; the first burst skips the burst average and push.
// Throughput: one sample per cycle within a burst; s_tready is low while a burst ends.
// Reset: aresetn is synchronous, active low; clears control state and loads register
// defaults. Window contents are undefined until the first burst fills them.

module battery_level_estimator_top #(
    parameter int BURST_SAMPLES = 10,
    parameter int WINDOW_DEPTH  = 10,
    parameter int TABLE_POINTS  = 11
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ble_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [ble_pkg::CFG_DW-1:0]         cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample[11:0], charging[12], precharge_idle[13], low_power_mode[14]
    input  logic [ble_pkg::TDATA_IN_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // level[6:0], red_pulse[7], full_indicator[8], shutdown_request[9]
    output logic [ble_pkg::TDATA_OUT_W-1:0]    m_tdata
);

    import ble_pkg::*;

    localparam int SUM_W  = $clog2(BURST_SAMPLES * 4095 + 1);
    localparam int TOT_W  = $clog2(WINDOW_DEPTH * 8190 + 1);
    localparam int NUM_W  = LEVEL_W + ENTRY_W;
    localparam int MAX_A  = (SUM_W + 1 > TOT_W) ? SUM_W + 1 : TOT_W;
    localparam int DIV_W  = NUM_W;
    localparam int DEN_W  = ENTRY_W;
    localparam int CNT_W  = $clog2(BURST_SAMPLES + 1);
    localparam int WCNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int TABLE_N = (TABLE_POINTS < VOLT_POINTS) ? TABLE_POINTS : VOLT_POINTS;
    localparam int SEL_W  = $clog2(TABLE_N);

    // exact floor division of a MAX_A-bit value by a constant: (x * ceil(2^k / d)) >> k
    localparam int REC_W  = MAX_A + 2;
    localparam int MUL_W  = MAX_A + REC_W;
    localparam int BURST_K  = MAX_A + $clog2(BURST_SAMPLES);
    localparam int WINDOW_K = MAX_A + $clog2(WINDOW_DEPTH);
    localparam longint BURST_M  =
        ((longint'(1) << BURST_K) + longint'(BURST_SAMPLES) - 1) / longint'(BURST_SAMPLES);
    localparam longint WINDOW_M =
        ((longint'(1) << WINDOW_K) + longint'(WINDOW_DEPTH) - 1) / longint'(WINDOW_DEPTH);
    localparam logic [REC_W-1:0] BURST_RECIP  = REC_W'(BURST_M);
    localparam logic [REC_W-1:0] WINDOW_RECIP = REC_W'(WINDOW_M);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_AVG_MUL  = 4'd1;
    localparam logic [3:0] ST_AVG_PUSH = 4'd2;
    localparam logic [3:0] ST_SUM      = 4'd3;
    localparam logic [3:0] ST_WIN_MUL  = 4'd4;
    localparam logic [3:0] ST_LOOK     = 4'd5;
    localparam logic [3:0] ST_LUT_WAIT = 4'd6;
    localparam logic [3:0] ST_FINISH   = 4'd7;

    // percent at each table point
    logic [LEVEL_W-1:0] pct_w [TABLE_N];
    for (genvar g = 0; g < TABLE_N; g++) begin : g_pct
        localparam int P = (g * 100) / (TABLE_POINTS - 1);
        assign pct_w[g] = LEVEL_W'(P);
    end

    logic [OFFS_W-1:0]  charge_offset_reg;
    logic [THR_W-1:0]   low_threshold_reg;
    logic [SHUT_W-1:0]  shutdown_after_reg;

    logic [3:0]         state_reg, state_next;
    logic [SUM_W-1:0]   burst_sum_reg, burst_sum_next;
    logic [CNT_W-1:0]   burst_count_reg, burst_count_next;
    logic               primed_reg, primed_next;
    logic [LEVEL_W-1:0] last_level_reg, last_level_next;
    logic [SHUT_W-1:0]  zero_run_reg, zero_run_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [WCNT_W-1:0]  sum_cnt_reg, sum_cnt_next;
    logic [ENTRY_W-1:0] v_reg, v_next;
    logic [LEVEL_W-1:0] raw_reg, raw_next;
    logic [LEVEL_W-1:0] pct_lo_reg, pct_lo_next;
    logic               chg_reg, chg_next;
    logic               pre_reg, pre_next;
    logic               lowm_reg, lowm_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic [SAMPLE_W-1:0] in_sample;
    logic               in_chg, in_pre, in_lowm, accept;

    win_ctrl_t          win_ctrl;
    logic [ENTRY_W-1:0] win_data, win_head;

    logic [MAX_A-1:0]   mul_a;
    logic [REC_W-1:0]   mul_b;
    logic [MUL_W-1:0]   mul_p;
    logic [ENTRY_W-1:0] mul_q;

    logic               div_start, div_done;
    logic [DIV_W-1:0]   div_dividend, div_quotient;
    logic [DEN_W-1:0]   div_divisor;

    logic [TABLE_N-1:0] le;
    logic [SEL_W-1:0]   sel, sel_lo;
    logic               seg_found;
    logic [SAMPLE_W-1:0] t_lo, t_hi;
    logic [LEVEL_W-1:0] pct_step;
    logic [ENTRY_W-1:0] v_off;
    logic [NUM_W-1:0]   lut_num;
    logic [LEVEL_W:0]   lut_sum;
    logic [LEVEL_W-1:0] level_f;
    logic               red_f, full_f, shut_f;

    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign in_chg    = s_tdata[SAMPLE_W];
    assign in_pre    = s_tdata[SAMPLE_W+1];
    assign in_lowm   = s_tdata[SAMPLE_W+2];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    ble_window #(
        .DEPTH (WINDOW_DEPTH),
        .W     (ENTRY_W)
    ) u_window (
        .aclk      (aclk),
        .ctrl      (win_ctrl),
        .push_data (win_data),
        .head      (win_head)
    );

    ble_div #(
        .DIV_W (DIV_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // shared reciprocal multiply: burst average, or window average in ST_WIN_MUL
    always_comb begin
        mul_a = (state_reg == ST_WIN_MUL) ? MAX_A'(total_reg) : MAX_A'({burst_sum_reg, 1'b0});
        mul_b = (state_reg == ST_WIN_MUL) ? WINDOW_RECIP : BURST_RECIP;
        mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
        mul_q = (state_reg == ST_WIN_MUL) ? ENTRY_W'(mul_p >> WINDOW_K)
                                          : ENTRY_W'(mul_p >> BURST_K);
    end

    // table segment search on the window average
    always_comb begin
        for (int i = 0; i < TABLE_N; i++) begin
            le[i] = ({1'b0, VOLT_TABLE[i]} >= v_reg);
        end
        sel = SEL_W'(TABLE_N - 1);
        seg_found = 1'b0;
        for (int i = TABLE_N - 1; i >= 1; i--) begin
            if (le[i]) begin
                sel = SEL_W'(i);
                seg_found = 1'b1;
            end
        end
        sel_lo   = sel - 1'b1;
        t_lo     = VOLT_TABLE[sel_lo];
        t_hi     = VOLT_TABLE[sel];
        pct_step = pct_w[sel] - pct_w[sel_lo];
        v_off    = v_reg - ENTRY_W'(t_lo);
        lut_num  = NUM_W'(pct_step * v_off);
        lut_sum  = {1'b0, pct_lo_reg} + {1'b0, div_quotient[LEVEL_W-1:0]};
    end

    // monotonic hold and status flags
    always_comb begin
        level_f = raw_reg;
        if (primed_reg) begin
            if (!chg_reg && last_level_reg < raw_reg) begin
                level_f = last_level_reg;
            end else if (chg_reg && last_level_reg > raw_reg) begin
                level_f = last_level_reg;
            end
        end
        red_f  = pre_reg && !chg_reg && !lowm_reg && (level_f <= low_threshold_reg);
        full_f = !pre_reg && (level_f >= LEVEL_FULL);
        if (level_f == '0) begin
            zero_run_next = (zero_run_reg < ZERO_RUN_MAX) ? zero_run_reg + 1'b1
                                                          : zero_run_reg;
        end else begin
            zero_run_next = '0;
        end
        shut_f = (level_f == '0) && (zero_run_next >= shutdown_after_reg);
    end

    always_comb begin
        state_next       = state_reg;
        burst_sum_next   = burst_sum_reg;
        burst_count_next = burst_count_reg;
        primed_next      = primed_reg;
        last_level_next  = last_level_reg;
        total_next       = total_reg;
        sum_cnt_next     = sum_cnt_reg;
        v_next           = v_reg;
        raw_next         = raw_reg;
        pct_lo_next      = pct_lo_reg;
        chg_next         = chg_reg;
        pre_next         = pre_reg;
        lowm_next        = lowm_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        win_ctrl         = '0;
        win_data         = sub_sat({in_sample, 1'b0}, charge_offset_reg, in_chg);
        div_start        = 1'b0;
        div_dividend     = DIV_W'(lut_num);
        div_divisor      = DEN_W'(t_hi - t_lo);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    burst_sum_next   = burst_sum_reg + SUM_W'(in_sample);
                    burst_count_next = burst_count_reg + 1'b1;
                    // first burst: every sample goes straight into the window
                    win_ctrl.push = !primed_reg;
                    if (burst_count_next == CNT_W'(BURST_SAMPLES)) begin
                        chg_next  = in_chg;
                        pre_next  = in_pre;
                        lowm_next = in_lowm;
                        burst_count_next = '0;
                        total_next   = '0;
                        sum_cnt_next = '0;
                        state_next = primed_reg ? ST_AVG_MUL : ST_SUM;
                        if (!primed_reg) begin
                            burst_sum_next = '0;
                        end
                    end
                end
            end
            ST_AVG_MUL: begin
                v_next         = mul_q;
                burst_sum_next = '0;
                state_next     = ST_AVG_PUSH;
            end
            ST_AVG_PUSH: begin
                win_data      = sub_sat(v_reg, charge_offset_reg, chg_reg);
                win_ctrl.push = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM: begin
                win_ctrl.rotate = 1'b1;
                total_next   = total_reg + TOT_W'(win_head);
                sum_cnt_next = sum_cnt_reg + 1'b1;
                if (sum_cnt_reg == WCNT_W'(WINDOW_DEPTH - 1)) begin
                    state_next = ST_WIN_MUL;
                end
            end
            ST_WIN_MUL: begin
                v_next     = mul_q;
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                pct_lo_next  = pct_w[sel_lo];
                if (le[0]) begin
                    raw_next   = '0;
                    state_next = ST_FINISH;
                end else if (!seg_found) begin
                    raw_next   = LEVEL_FULL;
                    state_next = ST_FINISH;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_LUT_WAIT;
                end
            end
            ST_LUT_WAIT: begin
                if (div_done) begin
                    raw_next   = (lut_sum > {1'b0, LEVEL_FULL}) ? LEVEL_FULL
                                                                 : lut_sum[LEVEL_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output slot is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next   = 1'b1;
                    m_tdata_next    = TDATA_OUT_W'({shut_f, full_f, red_f, level_f});
                    last_level_next = level_f;
                    primed_next     = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charge_offset_reg  <= CHARGE_OFFSET_RST;
            low_threshold_reg  <= LOW_THRESHOLD_RST;
            shutdown_after_reg <= SHUTDOWN_AFTER_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_IDX_CHARGE_OFFSET:  charge_offset_reg  <= cfg_wdata[OFFS_W-1:0];
                CFG_IDX_LOW_THRESHOLD:  low_threshold_reg  <= cfg_wdata[THR_W-1:0];
                CFG_IDX_SHUTDOWN_AFTER: shutdown_after_reg <= cfg_wdata[SHUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            burst_sum_reg   <= '0;
            burst_count_reg <= '0;
            primed_reg      <= 1'b0;
            last_level_reg  <= '0;
            zero_run_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            burst_sum_reg   <= burst_sum_next;
            burst_count_reg <= burst_count_next;
            primed_reg      <= primed_next;
            last_level_reg  <= last_level_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (state_reg == ST_FINISH && (!m_tvalid_reg || m_tready)) begin
                zero_run_reg <= zero_run_next;
            end
        end
        total_reg   <= total_next;
        sum_cnt_reg <= sum_cnt_next;
        v_reg       <= v_next;
        raw_reg     <= raw_next;
        pct_lo_reg  <= pct_lo_next;
        chg_reg     <= chg_next;
        pre_reg     <= pre_next;
        lowm_reg    <= lowm_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[LEVEL_W-1:0] <= LEVEL_FULL)
        else $error("level above full scale");

    a_shut_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[LEVEL_W+2] |-> m_tdata[LEVEL_W-1:0] == '0)
        else $error("shutdown request with nonzero level");

    a_red_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[LEVEL_W] && m_tdata[LEVEL_W+1]))
        else $error("low-battery pulse together with full indication");

    a_burst_count: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_count_reg < CNT_W'(BURST_SAMPLES))
        else $error("burst counter out of range");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> !div_start)
        else $error("divider restarted while finishing");

endmodule
